// ----- rtl/upd_pkg.sv -----
package upd_pkg;

  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_PERCENT  = 8'h25;
  localparam logic [7:0] CH_SPACE    = 8'h20;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_HEX  = 2'd2
  } phase_t;

  // Up to three decoded bytes from one input beat, slot 0 goes out first.
  typedef struct packed {
    logic [1:0]      cnt;
    logic            last;
    logic [2:0][7:0] data;
  } grp_t;

  typedef struct packed {
    logic       emit;
    logic       pend;
    logic [7:0] data;
  } plain_t;

  function automatic logic hex_ok(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Letters A-F / a-f have bit 6 set and low nibble 1..6.
  function automatic logic [3:0] hex_val(logic [7:0] c);
    return c[6] ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

  // Byte decoded outside an escape.
  function automatic plain_t plain_dec(logic [7:0] c, logic last, logic pas);
    plain_t p;
    p.emit = 1'b1;
    p.pend = 1'b0;
    p.data = c;
    if (c == CH_PERCENT) begin
      p.emit = last;
      p.pend = !last;
      p.data = CH_QUESTION;
    end else if (c == CH_PLUS) begin
      p.data = pas ? CH_SPACE : CH_PLUS;
    end
    return p;
  endfunction

endpackage

// ----- rtl/upd_dec.sv -----
module upd_dec (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output logic          grp_load,
  output upd_pkg::grp_t grp
);
  import upd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       pas_r;

  plain_t pb, ph;
  logic   b_hex, h_hex;

  assign b_hex = hex_ok(in_byte);
  assign h_hex = hex_ok(held_r);
  assign pb    = plain_dec(in_byte, in_last, pas_r);
  assign ph    = plain_dec(held_r, 1'b0, pas_r);

  // next state
  always_comb begin
    phase_nxt = PH_IDLE;
    held_nxt  = held_r;
    unique case (phase_r)
      PH_PCT: begin
        if (b_hex && !in_last) begin
          phase_nxt = PH_HEX;
          held_nxt  = in_byte;
        end else if (pb.pend) begin
          phase_nxt = PH_PCT;
        end
      end
      PH_HEX: begin
        if (!(h_hex && b_hex) && (ph.pend || pb.pend) && !in_last) phase_nxt = PH_PCT;
      end
      default: begin
        if (pb.pend) phase_nxt = PH_PCT;
      end
    endcase
  end

  // decoded bytes
  always_comb begin
    grp.cnt  = 2'd0;
    grp.last = in_last;
    grp.data = '0;
    unique case (phase_r)
      PH_PCT: begin
        if (!(b_hex && !in_last)) begin
          grp.cnt     = 2'd1 + {1'b0, pb.emit};
          grp.data[0] = CH_QUESTION;
          grp.data[1] = pb.data;
        end
      end
      PH_HEX: begin
        if (h_hex && b_hex) begin
          grp.cnt     = 2'd1;
          grp.data[0] = {hex_val(held_r), hex_val(in_byte)};
        end else begin
          grp.cnt     = 2'd1 + {1'b0, ph.emit} + {1'b0, pb.emit};
          grp.data[0] = CH_QUESTION;
          grp.data[1] = ph.emit ? ph.data : pb.data;
          grp.data[2] = pb.data;
        end
      end
      default: begin
        grp.cnt     = {1'b0, pb.emit};
        grp.data[0] = pb.data;
      end
    endcase
  end

  assign grp_load = accept && (grp.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= '0;
      pas_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) pas_r <= cfg_wr_data;
      if (accept) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
      end
    end
  end

endmodule

// ----- rtl/upd_ser.sv -----
module upd_ser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          grp_load,
  input  upd_pkg::grp_t grp,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last
);
  import upd_pkg::*;

  logic       a_valid_r, b_valid_r;
  grp_t       a_grp_r, b_grp_r;
  logic [1:0] idx_r;
  logic       b_end, b_pop_end, a_move;

  assign b_end     = (idx_r == b_grp_r.cnt - 2'd1);
  assign b_pop_end = b_valid_r && out_ready && b_end;
  assign a_move    = a_valid_r && (!b_valid_r || b_pop_end);
  assign in_ready  = !a_valid_r || a_move;

  assign out_valid = b_valid_r;
  assign out_byte  = b_grp_r.data[idx_r];
  assign out_last  = b_grp_r.last && b_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      if (grp_load)    a_valid_r <= 1'b1;
      else if (a_move) a_valid_r <= 1'b0;
      if (a_move) begin
        b_valid_r <= 1'b1;
        idx_r     <= '0;
      end else if (b_pop_end) begin
        b_valid_r <= 1'b0;
        idx_r     <= '0;
      end else if (b_valid_r && out_ready) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_load) a_grp_r <= grp;
    if (a_move)   b_grp_r <= a_grp_r;
  end

  a_never_empty_group: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> b_grp_r.cnt != 2'd0)
    else $error("serializer holds an empty group");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> idx_r < b_grp_r.cnt)
    else $error("serializer index past group size");

  a_a_drains: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !b_valid_r |=> b_valid_r)
    else $error("waiting group not moved to serializer");

  a_last_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && b_grp_r.last && !b_end |-> !out_last)
    else $error("tlast raised before the group's final beat");

endmodule

// ----- rtl/url_percent_decoder.sv -----
// Percent decoder for URL-encoded byte streams.
// in_*  : one encoded byte per beat, in_tlast closes a string.
// out_* : decoded bytes; '%' plus two hex digits becomes one byte, a broken
//         escape becomes '?' followed by the bytes it swallowed. out_tlast
//         sits on the final decoded byte of each string.
// cfg_wr_en / cfg_wr_data : plus_as_space, set it while the stream is idle.
// An input beat yields zero to three output beats. The decode runs in the
// accept cycle and lands in a holding register; a serializer register then
// sends the group one beat per cycle while out_tready is high. The first
// output beat shows once the group has moved on into the serializer register.
// Throughput: one input beat per cycle as long as each beat yields at most
// one byte and out_tready is high; a multi-byte beat ties up the serializer.
// When out_tready is low the holding register still takes one more input
// group, then in_tready drops.
// Reset clears the escape state and plus_as_space and empties both buffer registers.
module url_percent_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);
  import upd_pkg::*;

  logic accept, grp_load;
  grp_t grp;

  assign accept = in_tvalid && in_tready;

  upd_dec u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .accept     (accept),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .grp_load   (grp_load),
    .grp        (grp)
  );

  upd_ser u_ser (
    .clk      (clk),
    .rst_n    (rst_n),
    .grp_load (grp_load),
    .grp      (grp),
    .in_ready (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_byte (out_tdata),
    .out_last (out_tlast)
  );

endmodule

// ----- tb/sv/tb_url_percent_decoder.sv -----
`timescale 1ns / 100ps

module tb_url_percent_decoder;
  import upd_pkg::*;

  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int STALL_LIMIT    = 2000;
  localparam int RANDOM_ITEMS   = 360;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_beat_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic       cfg_wr_data;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] in_byte
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_byte
  logic       out_tlast;

  // decoder shadow state
  phase_t     esc_phase;
  logic [7:0] held_digit;
  logic       plus_mode;

  dec_beat_t  decoded_q[$];
  logic [7:0] step_bytes[$];
  logic [7:0] text_q[$];
  dec_beat_t  exp_beat;

  int err_count   = 0;
  int items_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  bit hold_req    = 1'b0;

  url_percent_decoder i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    if (c <= "9") begin
      v = c - "0";
    end else if (c <= "F") begin
      v = c - "A" + 8'd10;
    end else begin
      v = c - "a" + 8'd10;
    end
    return v[3:0];
  endfunction

  // byte outside any escape
  function automatic void decode_plain(input logic [7:0] c, input logic l);
    if (c == CH_PERCENT) begin
      if (l) begin
        step_bytes.push_back(CH_QUESTION);
      end else begin
        esc_phase = PH_PCT;
      end
    end else if (c == CH_PLUS) begin
      step_bytes.push_back(plus_mode ? CH_SPACE : CH_PLUS);
    end else begin
      step_bytes.push_back(c);
    end
  endfunction

  function automatic void decode_step(input logic [7:0] c, input logic l);
    phase_t    ph;
    dec_beat_t beat;
    ph = esc_phase;
    esc_phase = PH_IDLE;
    step_bytes.delete();
    case (ph)
      PH_PCT: begin
        if (is_hex(c) && !l) begin
          held_digit = c;
          esc_phase = PH_HEX;
        end else begin
          step_bytes.push_back(CH_QUESTION);
          decode_plain(c, l);
        end
      end
      PH_HEX: begin
        if (is_hex(c)) begin
          step_bytes.push_back({nibble_of(held_digit), nibble_of(c)});
        end else begin
          // broken escape: '?', then the held digit, then this byte as plain
          step_bytes.push_back(CH_QUESTION);
          decode_plain(held_digit, 1'b0);
          decode_plain(c, l);
        end
      end
      default: decode_plain(c, l);
    endcase
    if (l) esc_phase = PH_IDLE;
    foreach (step_bytes[i]) begin
      beat.data = step_bytes[i];
      beat.last = l && (i == step_bytes.size() - 1);
      decoded_q.push_back(beat);
    end
  endfunction

  task automatic send_beat(input logic [7:0] data, input logic l);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_step(data, l);
    items_sent++;
  endtask

  // sends text_q as one string, tlast on its final byte
  task automatic send_text();
    foreach (text_q[i]) send_beat(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_plus(input logic v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    plus_mode = v;
  endtask

  function automatic logic [7:0] rand_hex();
    int n;
    n = $urandom_range(0, 21);
    if (n < 10) return 8'("0" + n);
    if (n < 16) return 8'("A" + n - 10);
    return 8'("a" + n - 16);
  endfunction

  // mostly well-formed escapes and plain bytes, some broken escapes
  task automatic build_random_text(input int units);
    int kind;
    repeat (units) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: text_q.push_back(8'($urandom_range(0, 255)));
        4, 5, 6: begin
          text_q.push_back(CH_PERCENT);
          text_q.push_back(rand_hex());
          text_q.push_back(rand_hex());
        end
        7: text_q.push_back(CH_PLUS);
        8: begin
          text_q.push_back(CH_PERCENT);
          if ($urandom_range(0, 1)) text_q.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          text_q.push_back(CH_PERCENT);
          text_q.push_back(rand_hex());
          text_q.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  task automatic test_plain_and_escapes();
    text_q = '{8'h00, 8'hFF, CH_PLUS, CH_PERCENT, "0", "9", CH_PERCENT, "a", "F",
               CH_PERCENT, "f", "A"};
    send_text();
  endtask

  task automatic test_bad_escapes();
    // bad first digit, bad second digit, bad escape that starts a new one
    text_q = '{CH_PERCENT, "G", CH_PERCENT, "4", "Z", CH_PERCENT, CH_PERCENT, "4", "1"};
    send_text();
  endtask

  task automatic test_string_end();
    text_q = '{CH_PERCENT};
    send_text();
    text_q = '{CH_PERCENT, "4"};
    send_text();
    text_q = '{CH_PERCENT, "4", "x"};
    send_text();
  endtask

  task automatic test_plus_as_space();
    write_plus(1'b1);
    text_q = '{CH_PLUS, CH_PERCENT, "2", CH_PLUS, CH_PLUS};
    send_text();
  endtask

  task automatic test_backpressure();
    drain();
    hold_req = 1'b1;
    burst_left = 200;
    repeat (5) begin
      build_random_text(8);
      send_text();
    end
    drain();
  endtask

  task automatic test_random();
    int target;
    for (int p = 0; p < 4; p++) begin
      write_plus(p[0] ^ p[1]);
      target = items_sent + RANDOM_ITEMS / 4;
      while (items_sent < target) begin
        build_random_text($urandom_range(1, 10));
        send_text();
      end
    end
  endtask

  // receiver: stretches of always-ready, random stalls and a fixed pattern, plus a hold-off on request
  initial begin : rx_proc
    int mode;
    int len;
    int pat_cnt;
    pat_cnt = 0;
    out_tready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(10, 60);
        repeat (len) begin
          case (mode)
            0: out_tready <= 1'b1;
            1: out_tready <= 1'($urandom_range(0, 1));
            default: out_tready <= (pat_cnt % 5) != 4 && (pat_cnt % 7) != 3;
          endcase
          pat_cnt++;
          @(posedge clk);
          if (hold_req) break;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected beat, expected none, actual data=%h last=%b",
                 $time, out_tdata, out_tlast);
      end else begin
        exp_beat = decoded_q.pop_front();
        if (exp_beat.data !== out_tdata) begin
          err_count++;
          $display("%0t: out_byte mismatch, expected %h, actual %h",
                   $time, exp_beat.data, out_tdata);
        end
        if (exp_beat.last !== out_tlast) begin
          err_count++;
          $display("%0t: out_last mismatch, expected %b, actual %b",
                   $time, exp_beat.last, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("tb_url_percent_decoder failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    in_tlast    <= 1'b0;
    esc_phase  = PH_IDLE;
    held_digit = 8'h00;
    plus_mode  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_and_escapes();
    test_bad_escapes();
    test_string_end();
    test_plus_as_space();
    test_backpressure();
    test_random();

    drain();
    if (err_count == 0 && decoded_q.size() == 0) begin
      $display("tb_url_percent_decoder passed");
    end else begin
      $display("tb_url_percent_decoder failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/upd_pkg.sv
rtl/upd_dec.sv
rtl/upd_ser.sv
rtl/url_percent_decoder.sv
tb/sv/tb_url_percent_decoder.sv
